// ----- hw/rtl/fitm_pkg.sv -----
`timescale 1ns / 1ps

package fitm_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int COORD_BITS_DEF    = 16;

  localparam int IN_DATA_W   = 56;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 112;
  localparam int OUT_USER_W  = 2;

  localparam logic [2:0] OP_RELEASE  = 3'd0;
  localparam logic [2:0] OP_RESERVE  = 3'd1;
  localparam logic [2:0] OP_FIND_AT  = 3'd2;
  localparam logic [2:0] OP_FIND_FIT = 3'd3;
  localparam logic [2:0] OP_LARGEST  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic pop;
    logic push;
  } chain_ctrl_t;

endpackage

// ----- hw/rtl/free_interval_table_manager_top.sv -----
`timescale 1ns / 1ps

// channel | ports        | tdata fields (low bit up)              | tuser
// input   | in_t*        | range_start, range_end, want_length,   | op
//         |              | early_pick                             |
// result  | out_t*       | found_start, found_end, free_total,    | status
//         |              | occupied_total, entry_total,           |
//         |              | largest_length, largest_start          |
//
// one transaction at a time; the table lives in a row of cells that shift towards the head
// scan pass: rotates the row, counts the new table, finds, totals
// rewrite pass for release and reserve: one entry per cycle, stalling the reads while two new entries wait
// reset clears the row's valid bits, the span and the count; no clearing pass
// a result stalled by out_tready holds the block; in_tready is high only when idle

module free_interval_table_manager_top
  import fitm_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // range_start, range_end, want_length, early_pick
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // found_start, found_end, free_total, occupied_total, entry_total,
  // largest_length, largest_start
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int NW = $clog2(MAX_INTERVALS + 2);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [CB-1:0] s_r, s_nxt;
  logic [CB-1:0] e_r, e_nxt;
  logic [CB-1:0] len_r, len_nxt;
  logic          early_r, early_nxt;
  logic          mut_r, mut_nxt;
  logic          full_r, full_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [CB-1:0] ms_r, ms_nxt;
  logic [EB-1:0] me_r, me_nxt;
  logic          placed_r, placed_nxt;
  logic [CB-1:0] q_s_r [2];
  logic [CB-1:0] q_s_nxt [2];
  logic [EB-1:0] q_e_r [2];
  logic [EB-1:0] q_e_nxt [2];
  logic [1:0]    q_cnt_r, q_cnt_nxt;
  logic          done_r, done_nxt;
  logic [EB-1:0] fsum_r, fsum_nxt;
  logic [EB-1:0] blen_r, blen_nxt;
  logic [CB-1:0] bstart_r, bstart_nxt;
  logic          prev_v_r, prev_v_nxt;
  logic [EB-1:0] prev_e_r, prev_e_nxt;
  logic          seenk_r, seenk_nxt;
  logic          fnd_r, fnd_nxt;
  logic [CB-1:0] fs_r, fs_nxt;
  logic [EB-1:0] fe_r, fe_nxt;
  logic [EB-1:0] best_r, best_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CB-1:0] span_lo_r, span_lo_nxt;
  logic [EB-1:0] span_hi_r, span_hi_nxt;
  logic          span_known_r, span_known_nxt;

  chain_ctrl_t   ctrl;
  logic [CB-1:0] push_s;
  logic [EB-1:0] push_e;
  logic          head_v;
  logic [CB-1:0] head_s;
  logic [EB-1:0] head_e;

  logic [CB-1:0] in_s, in_e, in_len;
  logic          step, step_end;
  logic [1:0]    em_cnt;
  logic [CB-1:0] em0_s, em1_s;
  logic [EB-1:0] em0_e, em1_e;
  logic [CB-1:0] ms_c;
  logic [EB-1:0] me_c;
  logic          placed_c;
  logic [NW-1:0] n_fin;
  logic          tap_v;
  logic [CB-1:0] tap_s;
  logic [EB-1:0] tap_e;
  logic [EB-1:0] tap_len;
  logic [EB-1:0] avail;

  logic [1:0]    status_c;
  logic [CB-1:0] out_fs;
  logic [EB-1:0] out_fe;
  logic [EB-1:0] occ;

  fitm_chain #(.MAX_INTERVALS(MAX_INTERVALS), .CB(CB)) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .push_s (push_s),
    .push_e (push_e),
    .head_v (head_v),
    .head_s (head_s),
    .head_e (head_e)
  );

  assign in_s   = CB'(in_tdata[15:0]);
  assign in_e   = CB'(in_tdata[31:16]);
  assign in_len = CB'(in_tdata[47:32]);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  assign step_end = (idx_r == count_r);
  assign step     = (state_r == S_SCAN) ||
                    ((state_r == S_WRITE) && !done_r && (q_cnt_r <= 2'd1));

  always_comb begin
    ctrl.pop  = 1'b0;
    ctrl.push = 1'b0;
    push_s    = head_s;
    push_e    = head_e;
    tap_v     = 1'b0;
    tap_s     = head_s;
    tap_e     = head_e;
    if (state_r == S_SCAN) begin
      ctrl.pop  = !step_end;
      ctrl.push = !step_end;
      tap_v     = !step_end && head_v;
    end else if (state_r == S_WRITE) begin
      ctrl.pop  = step && !step_end;
      ctrl.push = (q_cnt_r != 2'd0);
      push_s    = q_s_r[0];
      push_e    = q_e_r[0];
      tap_v     = (q_cnt_r != 2'd0);
      tap_s     = q_s_r[0];
      tap_e     = q_e_r[0];
    end
  end

  assign tap_len = tap_e - EB'(tap_s);
  assign avail   = head_e - EB'(head_s);
  assign n_fin   = n_r + NW'(em_cnt);

  // new entries caused by one table entry, or by the end of the table
  always_comb begin
    em_cnt   = 2'd0;
    em0_s    = head_s;
    em0_e    = head_e;
    em1_s    = head_s;
    em1_e    = head_e;
    ms_c     = ms_r;
    me_c     = me_r;
    placed_c = placed_r;
    if (op_r == OP_RELEASE) begin
      if (step_end) begin
        if (!placed_r) begin
          em_cnt   = 2'd1;
          em0_s    = ms_r;
          em0_e    = me_r;
          placed_c = 1'b1;
        end
      end else if (head_e < EB'(ms_r)) begin
        em_cnt = 2'd1;
      end else if (EB'(head_s) <= me_r) begin
        if (head_s < ms_r) ms_c = head_s;
        if (head_e > me_r) me_c = head_e;
      end else if (!placed_r) begin
        em_cnt   = 2'd2;
        em0_s    = ms_r;
        em0_e    = me_r;
        placed_c = 1'b1;
      end else begin
        em_cnt = 2'd1;
      end
    end else if ((op_r == OP_RESERVE) && !step_end) begin
      if ((head_e <= EB'(s_r)) || (head_s >= e_r)) begin
        em_cnt = 2'd1;
      end else if ((head_s < s_r) && (head_e > EB'(e_r))) begin
        em_cnt = 2'd2;
        em0_e  = EB'(s_r);
        em1_s  = e_r;
      end else if (head_s < s_r) begin
        em_cnt = 2'd1;
        em0_e  = EB'(s_r);
      end else if (head_e > EB'(e_r)) begin
        em_cnt = 2'd1;
        em0_s  = e_r;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    len_nxt        = len_r;
    early_nxt      = early_r;
    mut_nxt        = mut_r;
    full_nxt       = full_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    ms_nxt         = ms_r;
    me_nxt         = me_r;
    placed_nxt     = placed_r;
    q_s_nxt        = q_s_r;
    q_e_nxt        = q_e_r;
    q_cnt_nxt      = q_cnt_r;
    done_nxt       = done_r;
    fsum_nxt       = fsum_r;
    blen_nxt       = blen_r;
    bstart_nxt     = bstart_r;
    prev_v_nxt     = prev_v_r;
    prev_e_nxt     = prev_e_r;
    seenk_nxt      = seenk_r;
    fnd_nxt        = fnd_r;
    fs_nxt         = fs_r;
    fe_nxt         = fe_r;
    best_nxt       = best_r;
    count_nxt      = count_r;
    span_lo_nxt    = span_lo_r;
    span_hi_nxt    = span_hi_r;
    span_known_nxt = span_known_r;

    if (tap_v) begin
      fsum_nxt = fsum_r + tap_len;
      if (tap_len > blen_r) begin
        blen_nxt   = tap_len;
        bstart_nxt = tap_s;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt  = S_SCAN;
          op_nxt     = in_tuser;
          s_nxt      = in_s;
          e_nxt      = in_e;
          len_nxt    = in_len;
          early_nxt  = in_tdata[48];
          mut_nxt    = ((in_tuser == OP_RELEASE) || (in_tuser == OP_RESERVE)) &&
                       (in_s < in_e);
          full_nxt   = 1'b0;
          idx_nxt    = '0;
          n_nxt      = '0;
          ms_nxt     = in_s;
          me_nxt     = EB'(in_e);
          placed_nxt = 1'b0;
          fsum_nxt   = '0;
          blen_nxt   = '0;
          bstart_nxt = '0;
          prev_v_nxt = 1'b0;
          prev_e_nxt = '0;
          seenk_nxt  = 1'b0;
          fnd_nxt    = 1'b0;
          fs_nxt     = '0;
          fe_nxt     = '0;
          best_nxt   = '0;
        end
      end
      S_SCAN: begin
        n_nxt      = n_fin;
        ms_nxt     = ms_c;
        me_nxt     = me_c;
        placed_nxt = placed_c;
        if (op_r == OP_FIND_AT) begin
          if (!fnd_r && !seenk_r) begin
            if (step_end) begin
              if (prev_v_r && (prev_e_r >= EB'(s_r)) &&
                  (prev_e_r - EB'(s_r) >= EB'(len_r))) begin
                fnd_nxt = 1'b1;
                fs_nxt  = s_r;
                fe_nxt  = EB'(s_r) + EB'(len_r);
              end
            end else if (head_s < s_r) begin
              prev_v_nxt = 1'b1;
              prev_e_nxt = head_e;
            end else begin
              seenk_nxt = 1'b1;
              if (avail >= EB'(len_r)) begin
                fnd_nxt = 1'b1;
                fs_nxt  = head_s;
                fe_nxt  = EB'(head_s) + EB'(len_r);
              end else if (prev_v_r && (prev_e_r >= EB'(s_r)) &&
                           (prev_e_r - EB'(s_r) >= EB'(len_r))) begin
                fnd_nxt = 1'b1;
                fs_nxt  = s_r;
                fe_nxt  = EB'(s_r) + EB'(len_r);
              end
            end
          end
        end else if (op_r == OP_FIND_FIT) begin
          if (!step_end && (avail >= EB'(len_r))) begin
            if (early_r) begin
              if (!fnd_r) begin
                fnd_nxt = 1'b1;
                fs_nxt  = head_s;
                fe_nxt  = EB'(head_s) + EB'(len_r);
              end
            end else if (!fnd_r || (avail < best_r)) begin
              fnd_nxt  = 1'b1;
              best_nxt = avail;
              fs_nxt   = head_s;
              fe_nxt   = EB'(head_s) + EB'(len_r);
            end
          end
        end
        if (step_end) begin
          full_nxt = mut_r && (n_fin > NW'(MAX_INTERVALS));
          if (mut_r && (n_fin <= NW'(MAX_INTERVALS))) begin
            state_nxt  = S_WRITE;
            idx_nxt    = '0;
            ms_nxt     = s_r;
            me_nxt     = EB'(e_r);
            placed_nxt = 1'b0;
            q_cnt_nxt  = 2'd0;
            done_nxt   = 1'b0;
            fsum_nxt   = '0;
            blen_nxt   = '0;
            bstart_nxt = '0;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_WRITE: begin
        if (step) begin
          ms_nxt     = ms_c;
          me_nxt     = me_c;
          placed_nxt = placed_c;
          if (step_end) begin
            done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
          q_s_nxt[0] = em0_s;
          q_e_nxt[0] = em0_e;
          q_s_nxt[1] = em1_s;
          q_e_nxt[1] = em1_e;
          q_cnt_nxt  = em_cnt;
        end else if (q_cnt_r != 2'd0) begin
          q_s_nxt[0] = q_s_r[1];
          q_e_nxt[0] = q_e_r[1];
          q_cnt_nxt  = q_cnt_r - 2'd1;
        end
        if (done_r && (q_cnt_r == 2'd0)) begin
          state_nxt      = S_OUT;
          count_nxt      = CW'(n_r);
          span_known_nxt = 1'b1;
          if (!span_known_r || (s_r < span_lo_r)) span_lo_nxt = s_r;
          if (!span_known_r || (EB'(e_r) > span_hi_r)) span_hi_nxt = EB'(e_r);
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      span_lo_r    <= '0;
      span_hi_r    <= '0;
      span_known_r <= 1'b0;
      q_cnt_r      <= '0;
      done_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      span_lo_r    <= span_lo_nxt;
      span_hi_r    <= span_hi_nxt;
      span_known_r <= span_known_nxt;
      q_cnt_r      <= q_cnt_nxt;
      done_r       <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    s_r      <= s_nxt;
    e_r      <= e_nxt;
    len_r    <= len_nxt;
    early_r  <= early_nxt;
    mut_r    <= mut_nxt;
    full_r   <= full_nxt;
    idx_r    <= idx_nxt;
    n_r      <= n_nxt;
    ms_r     <= ms_nxt;
    me_r     <= me_nxt;
    placed_r <= placed_nxt;
    q_s_r    <= q_s_nxt;
    q_e_r    <= q_e_nxt;
    fsum_r   <= fsum_nxt;
    blen_r   <= blen_nxt;
    bstart_r <= bstart_nxt;
    prev_v_r <= prev_v_nxt;
    prev_e_r <= prev_e_nxt;
    seenk_r  <= seenk_nxt;
    fnd_r    <= fnd_nxt;
    fs_r     <= fs_nxt;
    fe_r     <= fe_nxt;
    best_r   <= best_nxt;
  end

  always_comb begin
    status_c = ST_IGNORED;
    out_fs   = '0;
    out_fe   = '0;
    case (op_r) inside
      OP_RELEASE, OP_RESERVE: begin
        if (!mut_r) status_c = ST_IGNORED;
        else if (full_r) status_c = ST_FULL;
        else status_c = ST_OK;
      end
      OP_FIND_AT, OP_FIND_FIT: begin
        status_c = fnd_r ? ST_OK : ST_NOT_FOUND;
        if (fnd_r) begin
          out_fs = fs_r;
          out_fe = fe_r;
        end
      end
      OP_LARGEST: begin
        status_c = (blen_r != '0) ? ST_OK : ST_NOT_FOUND;
        if (blen_r != '0) begin
          out_fs = bstart_r;
          out_fe = EB'(bstart_r) + blen_r;
        end
      end
      default: status_c = ST_IGNORED;
    endcase
  end

  assign occ = span_known_r ? ((span_hi_r - EB'(span_lo_r)) - fsum_r) : '0;

  assign out_tuser = status_c;
  assign out_tdata = {5'd0, 16'(bstart_r), 17'(blen_r), 7'(count_r), 17'(occ),
                      17'(fsum_r), 17'(out_fe), 16'(out_fs)};

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_INTERVALS))
    else $error("entry count beyond table size");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("rewrite queue overrun");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready after accepting a transaction");
`endif

endmodule

// ----- hw/rtl/fitm_cell.sv -----
`timescale 1ns / 1ps

module fitm_cell
  import fitm_pkg::*;
#(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_ctrl_t   ctrl,
  input  logic          nb_v,
  input  logic [CB-1:0] nb_s,
  input  logic [CB:0]   nb_e,
  input  logic          prev_post_v,
  input  logic [CB-1:0] push_s,
  input  logic [CB:0]   push_e,
  output logic          v,
  output logic [CB-1:0] s,
  output logic [CB:0]   e,
  output logic          post_v
);

  logic          v_r, v_nxt;
  logic [CB-1:0] s_r, s_nxt;
  logic [CB:0]   e_r, e_nxt;
  logic          take;

  assign post_v = ctrl.pop ? nb_v : v_r;
  assign take   = ctrl.push && !post_v && prev_post_v;

  always_comb begin
    v_nxt = post_v;
    s_nxt = s_r;
    e_nxt = e_r;
    if (take) begin
      v_nxt = 1'b1;
      s_nxt = push_s;
      e_nxt = push_e;
    end else if (ctrl.pop) begin
      s_nxt = nb_s;
      e_nxt = nb_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    e_r <= e_nxt;
  end

  assign v = v_r;
  assign s = s_r;
  assign e = e_r;

endmodule

// ----- hw/rtl/fitm_chain.sv -----
`timescale 1ns / 1ps

module fitm_chain
  import fitm_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int CB            = COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_ctrl_t   ctrl,
  input  logic [CB-1:0] push_s,
  input  logic [CB:0]   push_e,
  output logic          head_v,
  output logic [CB-1:0] head_s,
  output logic [CB:0]   head_e
);

  logic          v_w    [MAX_INTERVALS+1];
  logic [CB-1:0] s_w    [MAX_INTERVALS+1];
  logic [CB:0]   e_w    [MAX_INTERVALS+1];
  logic          post_w [MAX_INTERVALS+1];

  assign v_w[MAX_INTERVALS] = 1'b0;
  assign s_w[MAX_INTERVALS] = '0;
  assign e_w[MAX_INTERVALS] = '0;
  assign post_w[0]          = 1'b1;

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    fitm_cell #(.CB(CB)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .nb_v        (v_w[i+1]),
      .nb_s        (s_w[i+1]),
      .nb_e        (e_w[i+1]),
      .prev_post_v (post_w[i]),
      .push_s      (push_s),
      .push_e      (push_e),
      .v           (v_w[i]),
      .s           (s_w[i]),
      .e           (e_w[i]),
      .post_v      (post_w[i+1])
    );
  end

  assign head_v = v_w[0];
  assign head_s = s_w[0];
  assign head_e = e_w[0];

endmodule

// ----- test/free_interval_table_manager_top_tb.sv -----
`timescale 1ns / 1ps

module free_interval_table_manager_top_tb;
  import fitm_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] found_start;
    logic [16:0] found_end;
    logic [16:0] free_total;
    logic [16:0] occupied_total;
    logic [6:0]  entry_total;
    logic [16:0] largest_length;
    logic [15:0] largest_start;
  } summary_t;

  class interval_scoreboard;
    int starts[MAX_INTERVALS_DEF];
    int ends[MAX_INTERVALS_DEF];
    int tmp_s[MAX_INTERVALS_DEF + 2];
    int tmp_e[MAX_INTERVALS_DEF + 2];
    int count;
    int span_lo;
    int span_hi;
    bit span_known;
    summary_t pending[$];
    int errors;

    function int commit(int n, int s, int e);
      if (n > MAX_INTERVALS_DEF) return ST_FULL;
      for (int i = 0; i < n; i++) begin
        starts[i] = tmp_s[i];
        ends[i] = tmp_e[i];
      end
      count = n;
      if (!span_known) begin
        span_lo = s;
        span_hi = e;
        span_known = 1;
      end else begin
        if (s < span_lo) span_lo = s;
        if (e > span_hi) span_hi = e;
      end
      return ST_OK;
    endfunction

    function int merge_free(int s, int e);
      int n, ms, me;
      bit placed;
      n = 0; ms = s; me = e; placed = 0;
      for (int i = 0; i < count; i++) begin
        if (ends[i] < ms) begin
          tmp_s[n] = starts[i]; tmp_e[n] = ends[i]; n++;
        end else if (starts[i] <= me) begin
          if (starts[i] < ms) ms = starts[i];
          if (ends[i] > me) me = ends[i];
        end else begin
          if (!placed) begin
            tmp_s[n] = ms; tmp_e[n] = me; n++; placed = 1;
          end
          tmp_s[n] = starts[i]; tmp_e[n] = ends[i]; n++;
        end
      end
      if (!placed) begin
        tmp_s[n] = ms; tmp_e[n] = me; n++;
      end
      return commit(n, s, e);
    endfunction

    function int carve(int s, int e);
      int n;
      n = 0;
      for (int i = 0; i < count; i++) begin
        if (ends[i] <= s || starts[i] >= e) begin
          tmp_s[n] = starts[i]; tmp_e[n] = ends[i]; n++;
        end else begin
          if (starts[i] < s) begin
            tmp_s[n] = starts[i]; tmp_e[n] = s; n++;
          end
          if (ends[i] > e) begin
            tmp_s[n] = e; tmp_e[n] = ends[i]; n++;
          end
        end
      end
      return commit(n, s, e);
    endfunction

    function int locate_at(int p, int len, output int fs, output int fe);
      int k, a, b;
      k = 0;
      while (k < count && starts[k] < p) k++;
      if (k < count) begin
        a = starts[k]; b = ends[k];
        if (a <= p && b - p >= len) begin
          fs = p; fe = p + len; return ST_OK;
        end else if (a > p && b - a >= len) begin
          fs = a; fe = a + len; return ST_OK;
        end
      end
      if (k > 0) begin
        b = ends[k - 1];
        if (b >= p && b - p >= len) begin
          fs = p; fe = p + len; return ST_OK;
        end
      end
      return ST_NOT_FOUND;
    endfunction

    function int locate_fit(int len, bit early, output int fs, output int fe);
      int best, avail;
      bit have;
      best = 0; have = 0;
      for (int i = 0; i < count; i++) begin
        avail = ends[i] - starts[i];
        if (avail < len) continue;
        if (early) begin
          fs = starts[i]; fe = starts[i] + len; return ST_OK;
        end
        if (!have || avail < best) begin
          have = 1; best = avail; fs = starts[i]; fe = starts[i] + len;
        end
      end
      return have ? ST_OK : ST_NOT_FOUND;
    endfunction

    function void note(logic [2:0] op, int s, int e, int len, bit early);
      int st, fs, fe, sum, big, big_s, l;
      summary_t r;
      fs = 0; fe = 0; sum = 0; big = 0; big_s = 0;
      case (op)
        OP_RELEASE:  st = (s >= e) ? ST_IGNORED : merge_free(s, e);
        OP_RESERVE:  st = (s >= e) ? ST_IGNORED : carve(s, e);
        OP_FIND_AT:  st = locate_at(s, len, fs, fe);
        OP_FIND_FIT: st = locate_fit(len, early, fs, fe);
        default:     st = ST_IGNORED;
      endcase
      for (int i = 0; i < count; i++) begin
        l = ends[i] - starts[i];
        sum += l;
        if (l > big) begin
          big = l; big_s = starts[i];
        end
      end
      if (op == OP_LARGEST) begin
        if (big == 0) st = ST_NOT_FOUND;
        else begin
          st = ST_OK; fs = big_s; fe = big_s + big;
        end
      end
      if (st != ST_OK) begin
        fs = 0; fe = 0;
      end
      r.status = 2'(st);
      r.found_start = 16'(fs);
      r.found_end = 17'(fe);
      r.free_total = 17'(sum);
      r.occupied_total = span_known ? 17'((span_hi - span_lo) - sum) : 17'd0;
      r.entry_total = 7'(count);
      r.largest_length = 17'(big);
      r.largest_start = 16'(big_s);
      pending.insert(pending.size(), r);
    endfunction

    function void check(summary_t got);
      summary_t w;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, got.status); errors++;
      end
      if (got.found_start !== w.found_start) begin
        $error("found_start: expected %0d, got %0d", w.found_start, got.found_start);
        errors++;
      end
      if (got.found_end !== w.found_end) begin
        $error("found_end: expected %0d, got %0d", w.found_end, got.found_end); errors++;
      end
      if (got.free_total !== w.free_total) begin
        $error("free_total: expected %0d, got %0d", w.free_total, got.free_total); errors++;
      end
      if (got.occupied_total !== w.occupied_total) begin
        $error("occupied_total: expected %0d, got %0d", w.occupied_total,
               got.occupied_total);
        errors++;
      end
      if (got.entry_total !== w.entry_total) begin
        $error("entry_total: expected %0d, got %0d", w.entry_total,
               got.entry_total);
        errors++;
      end
      if (got.largest_length !== w.largest_length) begin
        $error("largest_length: expected %0d, got %0d", w.largest_length,
               got.largest_length);
        errors++;
      end
      if (got.largest_start !== w.largest_start) begin
        $error("largest_start: expected %0d, got %0d", w.largest_start,
               got.largest_start);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  interval_scoreboard sb;
  int idle_mode;
  int quiet_cycles;
  summary_t got;

  free_interval_table_manager_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit roll_idle(bit receiver);
    case (idle_mode)
      1: return !receiver && ($urandom_range(0, 99) < 73);
      2: return receiver && ($urandom_range(0, 99) < 73);
      3: return $urandom_range(0, 99) < 11;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n) out_tready = !roll_idle(1);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.found_start = out_tdata[15:0];
      got.found_end = out_tdata[32:16];
      got.free_total = out_tdata[49:33];
      got.occupied_total = out_tdata[66:50];
      got.entry_total = out_tdata[73:67];
      got.largest_length = out_tdata[90:74];
      got.largest_start = out_tdata[106:91];
      sb.check(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 6000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_op(logic [2:0] op, int s, int e, int len, bit early);
    if (roll_idle(0)) begin
      in_tvalid = 0;
      @(negedge clk);
      while (roll_idle(0)) @(negedge clk);
    end
    in_tdata = '0;
    in_tdata[15:0] = 16'(s);
    in_tdata[31:16] = 16'(e);
    in_tdata[47:32] = 16'(len);
    in_tdata[48] = early;
    in_tuser = op;
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    sb.note(op, s & 16'hffff, e & 16'hffff, len & 16'hffff, early);
    @(negedge clk);
  endtask

  task automatic send_random();
    int pick, s, e, len;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_RELEASE;
    else if (pick < 62) op = OP_RESERVE;
    else if (pick < 72) op = OP_FIND_AT;
    else if (pick < 85) op = OP_FIND_FIT;
    else if (pick < 95) op = OP_LARGEST;
    else op = 3'($urandom_range(5, 7));
    s = $urandom_range(0, 65535);
    case ($urandom_range(0, 15))
      0, 1: e = $urandom_range(0, 65535);
      2: e = $urandom_range(0, s);
      3: e = s + $urandom_range(1, 20000);
      default: e = s + $urandom_range(1, (op == OP_RESERVE) ? 400 : 3000);
    endcase
    if (e > 65535) e = 65535;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
    send_op(op, s, e, len, $urandom_range(0, 1));
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    clk = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 0;
    idle_mode = 0;
    quiet_cycles = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    send_op(OP_LARGEST, 0, 0, 0, 0);
    send_op(OP_FIND_FIT, 0, 0, 1, 1);
    send_op(OP_FIND_AT, 0, 0, 0, 0);
    send_op(OP_RESERVE, 0, 65535, 0, 0);
    send_op(OP_RELEASE, 0, 65535, 0, 0);
    send_op(OP_RESERVE, 100, 200, 0, 0);
    send_op(OP_RELEASE, 5, 5, 0, 0);
    send_op(OP_RESERVE, 9, 3, 0, 0);
    send_op(OP_FIND_AT, 0, 0, 0, 0);
    send_op(OP_FIND_AT, 150, 0, 10, 0);
    send_op(OP_FIND_AT, 65534, 0, 1, 0);
    send_op(OP_FIND_AT, 0, 0, 65535, 1);
    send_op(OP_FIND_FIT, 0, 0, 1, 1);
    send_op(OP_FIND_FIT, 0, 0, 1, 0);
    send_op(OP_FIND_FIT, 0, 0, 65535, 0);
    send_op(OP_LARGEST, 0, 0, 0, 0);
    send_op(3'd5, 1, 2, 3, 1);
    send_op(3'd6, 65535, 65535, 65535, 0);
    send_op(3'd7, 0, 0, 0, 0);
    send_op(OP_RESERVE, 1000, 1010, 0, 0);
    send_op(OP_RELEASE, 990, 1000, 0, 0);
    send_op(OP_RELEASE, 1010, 1020, 0, 0);

    for (int i = 0; i < 1650; i++) begin
      idle_mode = (i / 140) % 4;
      if (i == 800) begin
        in_tvalid = 0;
        wait_drained();
      end
      send_random();
    end
    in_tvalid = 0;
    wait_drained();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
